### hdl/ip_allowlist_bucket_table_unit_macros.svh
// Assertion macros for the allowlist bucket table unit.
`ifndef IP_ALLOWLIST_BUCKET_TABLE_UNIT_MACROS_SVH
`define IP_ALLOWLIST_BUCKET_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ALWB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alwb assertion failed");
`define ALWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alwb assertion failed");
`else
`define ALWB_ASSERT(lbl, prop)
`define ALWB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/alwb_pkg.sv
// Package: sizes, codes and controller/datapath types for the allowlist table.
package alwb_pkg;

  localparam int BUCKET_DEPTH = 512;
  localparam int BUCKET_BITS  = 5;
  localparam int IP_W         = 32;
  localparam int STATUS_W     = 2;
  localparam int NUM_BUCKETS  = 1 << BUCKET_BITS;
  localparam int SLOT_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W       = BUCKET_BITS + SLOT_W;
  localparam int MEM_DEPTH    = 1 << ADDR_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_TRUSTED   = 2'd2,
    ST_UNTRUSTED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    ins_commit;
    logic    scan_step;
    logic    res_load;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic ip_zero;
    logic full;
    logic empty_bkt;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

### hdl/alwb_ifs.sv
// Valid/ready channel interfaces for request and result words.
interface alwb_in_if;
  import alwb_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [IP_W-1:0] ip;
  modport source (output valid, output kind, output ip, input ready);
  modport sink   (input valid, input kind, input ip, output ready);
endinterface

interface alwb_out_if;
  import alwb_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

### hdl/alwb_ctrl.sv
// Controller state machine: sequences insert, bucket scan and result hand-off.
module alwb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  alwb_pkg::sts_t st,
  output alwb_pkg::cmd_t cmd
);
  import alwb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (st.is_check && !st.ip_zero && !st.empty_bkt) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (st.hit || st.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.res_code = ST_INSERTED;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        if (!st.is_check) begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = st.full ? ST_FULL : ST_INSERTED;
          // zero would land in an empty slot and leave it empty
          cmd.ins_commit = !st.full && !st.ip_zero;
        end else if (st.ip_zero || st.empty_bkt) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_UNTRUSTED;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_TRUSTED;
        end else if (st.last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_UNTRUSTED;
        end
      end
      S_DONE: begin
        cmd.out_load = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/alwb_dp.sv
// Datapath: address store, per-bucket fill counts, scan pipeline, result register.
module alwb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_kind,
  input  logic [alwb_pkg::IP_W-1:0]     in_ip,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [alwb_pkg::STATUS_W-1:0] out_status,
  input  alwb_pkg::cmd_t                cmd,
  output alwb_pkg::sts_t                st
);
  import alwb_pkg::*;

  logic [IP_W-1:0]     allow_mem_r [MEM_DEPTH];
  logic [CNT_W-1:0]    fill_r      [NUM_BUCKETS];

  logic                kind_r;
  logic [IP_W-1:0]     ip_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    ridx_r;
  logic                rvalid_r;
  logic [IP_W-1:0]     rdata_r;
  status_t             res_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [BUCKET_BITS-1:0] bkt;
  logic [BUCKET_BITS-1:0] in_bkt;
  logic                   issue;

  assign bkt    = ip_r[BUCKET_BITS-1:0];
  assign in_bkt = in_ip[BUCKET_BITS-1:0];
  assign issue  = cmd.scan_step && (idx_r < cnt_r);

  // store: one write (insert), one registered read (scan)
  always_ff @(posedge clk) begin
    if (cmd.ins_commit) begin
      allow_mem_r[{bkt, cnt_r[SLOT_W-1:0]}] <= ip_r;
    end
    if (issue) begin
      rdata_r <= allow_mem_r[{bkt, idx_r[SLOT_W-1:0]}];
    end
  end

  // fill counts stand in for clearing the store: slots below the count hold nonzero words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUCKETS; b++) fill_r[b] <= '0;
    end else if (cmd.ins_commit) begin
      fill_r[bkt] <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      ip_r   <= in_ip;
      cnt_r  <= fill_r[in_bkt];
    end
    if (cmd.res_load) begin
      res_r <= cmd.res_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_r;
    end
    if (issue) begin
      ridx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r    <= '0;
        rvalid_r <= 1'b0;
      end else begin
        if (issue) idx_r <= idx_r + CNT_W'(1);
        rvalid_r <= issue;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.is_check  = (kind_r == KIND_CHECK);
    st.ip_zero   = (ip_r == '0);
    st.full      = (cnt_r == CNT_W'(BUCKET_DEPTH));
    st.empty_bkt = (cnt_r == '0);
    st.hit       = rvalid_r && (rdata_r == ip_r);
    st.last      = rvalid_r && ((ridx_r + CNT_W'(1)) == cnt_r);
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

### hdl/ip_allowlist_bucket_table_unit.sv
// Insert: capture, dispatch, then result hand-off; a new word waits for that hand-off.
// Check: the same when the bucket is empty or the address is zero, otherwise a scan of
//   up to fill slots (at most BUCKET_DEPTH), one store read per slot scanned.
// The scan length is set by the single read port of the address store.
// Reset clears the per-bucket fill counts; the store itself is not swept,
//   so words are accepted as soon as reset is released.
`include "ip_allowlist_bucket_table_unit_macros.svh"

module ip_allowlist_bucket_table_unit (
  input  logic       clk,
  input  logic       rst_n,
  alwb_in_if.sink    in_ch,
  alwb_out_if.source out_ch
);
  import alwb_pkg::*;

  cmd_t cmd;
  sts_t st;

  alwb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  alwb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_ch.kind),
    .in_ip      (in_ch.ip),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .st         (st)
  );

  `ALWB_ASSERT(a_no_write_full, cmd.ins_commit |-> (!st.full && !st.ip_zero))
  `ALWB_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ALWB_ASSERT(a_out_load_free, cmd.out_load |-> st.out_free)
  `ALWB_ASSERT(a_scan_check_only, cmd.scan_step |-> (st.is_check && !st.ip_zero))

endmodule

### sim/alwb_status_checker.sv
// Checker for the allowlist table: tracks the bucket contents and compares each status word.
`timescale 1ns / 1ps

module alwb_status_checker
  import alwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  alwb_in_if          in_mon,
  alwb_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  // addresses held per bucket; zero is never stored since it reads as empty
  logic [IP_W-1:0] bucket_ips [NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned     bucket_fill [NUM_BUCKETS];
  status_t         status_due [$];
  int unsigned     bad_words;

  function automatic status_t lookup_status(kind_t k, logic [IP_W-1:0] a);
    logic [BUCKET_BITS-1:0] b;
    int unsigned            n;
    b = a[BUCKET_BITS-1:0];
    n = bucket_fill[b];
    if (k == KIND_INSERT) begin
      if (n == BUCKET_DEPTH) return ST_FULL;
      // writing zero into the first free slot leaves the bucket as it was
      if (a != '0) begin
        bucket_ips[b][n] = a;
        bucket_fill[b]   = n + 1;
      end
      return ST_INSERTED;
    end
    // empty test wins over match, so address zero never hits
    if (a == '0) return ST_UNTRUSTED;
    for (int i = 0; i < n; i++) begin
      if (bucket_ips[b][i] == a) return ST_TRUSTED;
    end
    return ST_UNTRUSTED;
  endfunction

  initial begin
    bad_words   = 0;
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch
    status_t want;
    status_t got;
    if (!rst_n) begin
      foreach (bucket_fill[i]) bucket_fill[i] = 0;
      status_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        status_due.push_back(lookup_status(kind_t'(in_mon.kind), in_mon.ip));
      if (out_mon.valid && out_mon.ready) begin
        got = status_t'(out_mon.status);
        if (status_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: status word %0d arrived with nothing pending", $realtime,
                     out_mon.status);
        end else begin
          want = status_due.pop_front();
          if (out_mon.status !== want) begin
            bad_words++;
            if (bad_words <= 10)
              $display("%0t: status expected %0d (%s), got %0d (%s)", $realtime,
                       want, want.name(), out_mon.status, got.name());
          end
        end
      end
    end
    mismatches  <= bad_words;
    outstanding <= status_due.size();
  end

endmodule

### sim/ip_allowlist_bucket_table_unit_test.sv
// Testbench top for the allowlist table: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module ip_allowlist_bucket_table_unit_test;
  import alwb_pkg::*;

  localparam int          WORDS_PER_PHASE = 288;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned HOLD_CYCLES     = 300;

  logic            clk = 1'b0;
  logic            rst_n;
  int unsigned     mismatches;
  int unsigned     outstanding;
  int unsigned     tx_idle_pct;
  int unsigned     rx_stall_pct;
  logic            hold_go;
  logic            hold_taken;
  int unsigned     hold_left;
  int unsigned     quiet_cycles;
  logic [IP_W-1:0] known_ips [$];
  logic [BUCKET_BITS-1:0] hot_bkt;

  alwb_in_if  in_ch ();
  alwb_out_if out_ch ();

  ip_allowlist_bucket_table_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alwb_status_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_taken   <= 1'b1;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays up between back-to-back words; it only drops during a gap or while results drain
  task automatic send_word(input kind_t k, input logic [IP_W-1:0] a);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.ip    <= a;
    if (k == KIND_INSERT && a != '0) known_ips.push_back(a);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // mostly traffic into one bucket so it fills up and later reports full
  task automatic send_random_word();
    int unsigned     pick;
    int unsigned     sub;
    logic [IP_W-1:0] a;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    a    = $urandom;
    if (pick < 55) begin
      if (sub < 8 && known_ips.size() != 0)
        a = known_ips[$urandom_range(0, known_ips.size() - 1)];
      else if (sub < 93)
        a[BUCKET_BITS-1:0] = hot_bkt;
      else if (sub == 99)
        a = '0;
      send_word(KIND_INSERT, a);
    end else begin
      if (sub < 50 && known_ips.size() != 0)
        a = known_ips[$urandom_range(0, known_ips.size() - 1)];
      else if (sub < 70)
        a[BUCKET_BITS-1:0] = hot_bkt;
      else if (sub < 75)
        a = '0;
      else if (sub < 80)
        a = '1;
      send_word(KIND_CHECK, a);
    end
  endtask

  initial begin : stim
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.kind   <= KIND_INSERT;
    in_ch.ip     <= '0;
    hold_go      <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hot_bkt      = BUCKET_BITS'($urandom_range(0, NUM_BUCKETS - 1));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero address, duplicates, misses
    send_word(KIND_CHECK,  32'hFFFF_FFFF);
    send_word(KIND_CHECK,  32'h0000_0000);
    send_word(KIND_INSERT, 32'h0000_0000);
    send_word(KIND_CHECK,  32'h0000_0000);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_CHECK,  32'hFFFF_FFFF);
    send_word(KIND_INSERT, 32'hFFFF_FFFF);
    send_word(KIND_CHECK,  32'h7FFF_FFFF);
    send_word(KIND_INSERT, 32'h8000_0000);
    send_word(KIND_CHECK,  32'h8000_0000);
    send_word(KIND_CHECK,  32'h0000_0020);
    send_word(KIND_INSERT, 32'h0000_0001);
    send_word(KIND_CHECK,  32'h0000_0001);
    send_word(KIND_INSERT, 32'hAAAA_AAAA);
    send_word(KIND_INSERT, 32'h5555_5555);
    send_word(KIND_CHECK,  32'hAAAA_AAAA);
    send_word(KIND_CHECK,  32'h5555_5555);
    send_word(KIND_INSERT, 32'h0000_0000);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 0 && n == 40) hold_go <= 1'b1;
        send_random_word();
      end
      drain_results();
    end

    repeat (BUCKET_DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
